>>> rtl/lpam_pkg.sv
// lpam_pkg: constants and state type for the largest-prime sieve unit
// no dependencies
package lpam_pkg;

  localparam int unsigned MAX_LIMIT = 65535;
  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int SW = AW + 1;

  localparam logic [AW-1:0] FIRST_PRIME  = AW'(2);
  localparam logic [SW-1:0] FIRST_SQUARE = SW'(4);
  localparam logic [15:0]   PRIME_NONE   = 16'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_J_RD,
    ST_J_WAIT,
    ST_CROSS,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_DONE
  } lpam_state_t;

endpackage

>>> rtl/largest_prime_at_most_unit.sv
// largest_prime_at_most_unit: sieve of eratosthenes over a one-bit mark memory
// depends on lpam_pkg
// steps for limit n >= 2: fill marks 0..n, read each root j with j*j <= n and, for each
//   prime root, cross out its multiples from j*j up to n; then scan down from n to a prime
// limit below 2: idle goes straight to done with result PRIME_NONE; one item at a time, the next start
//   is taken the cycle after done; done cannot stall
// rst clears control only; mark memory is undefined and rewritten per item with limit >= 2
module largest_prime_at_most_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] limit,
  output logic        done,
  output logic [15:0] prime
);
  import lpam_pkg::*;

  lpam_state_t state, state_next;

  logic [AW-1:0] n;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [SW-1:0] sq;
  logic [SW-1:0] m;
  logic [15:0]   result;

  logic          marks [0:MAX_LIMIT];
  logic          rd_bit;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_wdata;

  logic [31:0]   lim_wide;
  logic [AW-1:0] n_in;
  logic          sq_over;
  logic          m_over;

  assign lim_wide = 32'(limit);
  assign n_in     = (lim_wide > 32'(MAX_LIMIT)) ? AW'(MAX_LIMIT) : AW'(lim_wide);
  assign sq_over  = sq > {1'b0, n};
  assign m_over   = m > {1'b0, n};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      marks[mem_addr] <= mem_wdata;
    end
    rd_bit <= marks[mem_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (n_in < FIRST_PRIME) ? ST_DONE : ST_FILL;
        end
      end
      ST_FILL: begin
        if (i == n) begin
          state_next = ST_J_RD;
        end
      end
      ST_J_RD:      state_next = sq_over ? ST_SCAN_RD : ST_J_WAIT;
      ST_J_WAIT:    state_next = rd_bit ? ST_CROSS : ST_J_RD;
      ST_CROSS: begin
        if (m_over) begin
          state_next = ST_J_RD;
        end
      end
      ST_SCAN_RD:   state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_next = rd_bit ? ST_DONE : ST_SCAN_RD;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = state != ST_IDLE;
    done      = state == ST_DONE;
    prime     = result;
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_addr  = i;
    case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = i >= FIRST_PRIME;
      end
      ST_J_RD: begin
        mem_addr = j;
      end
      ST_CROSS: begin
        mem_addr = m[AW-1:0];
        mem_we   = !m_over;
      end
      default: begin
        mem_addr = i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      ST_IDLE: begin
        n      <= n_in;
        i      <= '0;
        j      <= FIRST_PRIME;
        sq     <= FIRST_SQUARE;
        result <= PRIME_NONE;
      end
      ST_FILL: begin
        if (i == n) begin
          i <= n;
        end else begin
          i <= i + AW'(1);
        end
      end
      ST_J_WAIT: begin
        if (rd_bit) begin
          m <= sq;
        end else begin
          j  <= j + AW'(1);
          sq <= sq + {j, 1'b1};
        end
      end
      ST_CROSS: begin
        if (m_over) begin
          j  <= j + AW'(1);
          sq <= sq + {j, 1'b1};
        end else begin
          m <= m + SW'(j);
        end
      end
      ST_SCAN_WAIT: begin
        if (rd_bit) begin
          result <= 16'(i);
        end else begin
          i <= i - AW'(1);
        end
      end
      default: begin
        result <= result;
      end
    endcase
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (i <= n))
    else $error("fill address beyond limit");

  a_scan_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_WAIT) |-> (i >= FIRST_PRIME))
    else $error("scan went below first prime");

  a_cross_from_square: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CROSS && $past(state) == ST_J_WAIT) |-> (m == sq))
    else $error("crossing did not start at root square");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("done strobe longer than one cycle");

  a_prime_bound: assert property (@(posedge clk) disable iff (rst)
    (done && n >= FIRST_PRIME) |-> (32'(result) <= 32'(n) && result >= 16'(FIRST_PRIME)))
    else $error("result outside two to limit");

endmodule

>>> sim/tb_largest_prime_at_most_unit.sv
// tb_largest_prime_at_most_unit: self-checking bench for the largest-prime sieve unit
// drives limits over the start/busy handshake and checks every done strobe against a
// trial-division predictor; depends on lpam_pkg and largest_prime_at_most_unit
module tb_largest_prime_at_most_unit;
  import lpam_pkg::*;

  localparam int STALL_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 80;
  localparam int QUIET_TAIL = 20;

  class largest_prime_tracker;
    logic [15:0] expected_primes[$];
    logic [15:0] pending_limits[$];
    int mismatch_count = 0;

    static function bit is_prime(int unsigned value);
      int unsigned divisor;
      if (value < 2) return 1'b0;
      for (divisor = 2; divisor * divisor <= value; divisor++) begin
        if (value % divisor == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    static function logic [15:0] largest_prime_le(logic [15:0] bound);
      int unsigned capped;
      int unsigned candidate;
      capped = bound;
      if (capped > MAX_LIMIT) capped = MAX_LIMIT;
      if (capped < 2) return PRIME_NONE;
      for (candidate = capped; candidate >= 2; candidate--) begin
        if (is_prime(candidate)) return 16'(candidate);
      end
      return PRIME_NONE;
    endfunction

    function void note_limit(logic [15:0] bound);
      expected_primes = {expected_primes, largest_prime_le(bound)};
      pending_limits = {pending_limits, bound};
    endfunction

    function void check_prime(logic [15:0] actual);
      logic [15:0] wanted;
      logic [15:0] bound;
      if (expected_primes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: prime %0d with no item outstanding", actual);
        return;
      end
      wanted = expected_primes.pop_front();
      bound = pending_limits.pop_front();
      if (actual !== wanted) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: limit %0d expected prime %0d got %0d", bound, wanted, actual);
      end
    endfunction

    function int outstanding();
      return expected_primes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] limit;
  logic        done;
  logic [15:0] prime;

  largest_prime_tracker tracker = new;
  int stall_cycles = 0;

  largest_prime_at_most_unit dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .limit (limit),
    .done  (done),
    .prime (prime)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_prime(prime);
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("largest_prime_at_most_unit test failed");
      $finish;
    end
  end

  task automatic send_limit(input logic [15:0] bound);
    @(negedge clk);
    start = 1'b1;
    limit = bound;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    tracker.note_limit(bound);
  endtask

  task automatic idle_burst();
    int gap;
    gap = $urandom_range(5, 1);
    @(negedge clk);
    start = 1'b0;
    limit = 16'($urandom);
    repeat (gap - 1) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return 16'($urandom_range(65535));
    if (roll < 15) return 16'($urandom_range(8191));
    if (roll < 25) return 16'($urandom_range(15));
    return 16'($urandom_range(1023));
  endfunction

  initial begin
    logic [15:0] directed_limits[$];
    int item_index;
    directed_limits = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd8,
                        16'd9, 16'd24, 16'd25, 16'd48, 16'd49, 16'd120, 16'd121,
                        16'd168, 16'd169, 16'd1000, 16'd1024, 16'd4096, 16'd16384,
                        16'd65535};
    rst = 1'b1;
    start = 1'b0;
    limit = 16'd0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (directed_limits[k]) begin
      send_limit(directed_limits[k]);
      if ($urandom_range(2) == 0) idle_burst();
    end

    for (item_index = 0; item_index < RANDOM_ITEMS; item_index++) begin
      send_limit(pick_limit());
      if (item_index < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(2) == 0) idle_burst();
    end

    @(negedge clk);
    start = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
      $display("largest_prime_at_most_unit test passed");
    end else begin
      $display("largest_prime_at_most_unit test failed");
    end
    $finish;
  end

endmodule
